FILE: rtl/per_cpu_page_free_list_top_macros.svh
`ifndef PER_CPU_PAGE_FREE_LIST_TOP_MACROS_SVH
`define PER_CPU_PAGE_FREE_LIST_TOP_MACROS_SVH

// same-cycle implication, checked on clk while out of reset
`define PCPFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCPFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pcpfl_pkg.sv
package pcpfl_pkg;

  localparam int DEF_NUM_REQUESTERS = 8;
  localparam int DEF_PAGE_BYTES     = 4096;
  localparam int DEF_MAX_PAGES      = 32768;

  localparam int          ADDR_BITS = 32;
  localparam logic [31:0] ADDR_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [1:0] ST_FREED = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_OOM   = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic CFG_REGION_START = 1'b0;
  localparam logic CFG_REGION_STOP  = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_valid;
  } head_ctl_t;

endpackage

FILE: rtl/pcpfl_addr_check.sv
module pcpfl_addr_check #(
  parameter int PAGE_BYTES = pcpfl_pkg::DEF_PAGE_BYTES,
  parameter int MAX_PAGES  = pcpfl_pkg::DEF_MAX_PAGES,
  parameter int SW         = $clog2(MAX_PAGES)
) (
  input  logic [31:0]   region_start,
  input  logic [31:0]   region_stop,
  input  logic [32:0]   base,
  input  logic [31:0]   addr,
  output logic          bad,
  output logic [SW-1:0] slot
);
  import pcpfl_pkg::*;

  localparam int          Sh      = $clog2(PAGE_BYTES);
  localparam logic [32:0] MaxSlot = 33'(MAX_PAGES);

  logic [32:0] a;
  logic [32:0] diff;
  logic [32:0] slot_full;

  always_comb begin
    a         = {1'b0, addr & ADDR_MASK};
    diff      = a - base;
    slot_full = diff >> Sh;
    bad = (|a[Sh-1:0])
       || (a < {1'b0, region_start & ADDR_MASK})
       || (a >= {1'b0, region_stop & ADDR_MASK})
       || (a < base)
       || (slot_full >= MaxSlot);
    slot = slot_full[SW-1:0];
  end

endmodule

FILE: rtl/pcpfl_head_store.sv
module pcpfl_head_store #(
  parameter int NUM_REQUESTERS = pcpfl_pkg::DEF_NUM_REQUESTERS,
  parameter int SW             = 15,
  parameter int IW             = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pcpfl_pkg::head_ctl_t ctl,
  input  logic [IW-1:0]        rd_addr,
  input  logic [IW-1:0]        wr_addr,
  input  logic [SW-1:0]        wr_slot,
  input  logic [IW-1:0]        search_start,
  output logic                 any_valid,
  output logic [IW-1:0]        winner,
  output logic [SW-1:0]        rd_slot,
  output logic                 rd_valid
);
  import pcpfl_pkg::*;

  logic [SW-1:0]             mem [NUM_REQUESTERS];
  logic [NUM_REQUESTERS-1:0] valid_r;

  // round-robin pick: first valid list at or after the start id
  always_comb begin
    logic [7:0] idx;
    any_valid = 1'b0;
    winner    = '0;
    for (int k = 0; k < NUM_REQUESTERS; k++) begin
      idx = 8'(search_start) + 8'(k);
      if (idx >= 8'(NUM_REQUESTERS)) begin
        idx = idx - 8'(NUM_REQUESTERS);
      end
      if (!any_valid && valid_r[idx[IW-1:0]]) begin
        any_valid = 1'b1;
        winner    = idx[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_slot;
    end
    if (ctl.rd_en) begin
      rd_slot  <= mem[rd_addr];
      rd_valid <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_addr] <= ctl.wr_valid;
    end
  end

endmodule

FILE: rtl/pcpfl_link_store.sv
module pcpfl_link_store #(
  parameter int MAX_PAGES = pcpfl_pkg::DEF_MAX_PAGES,
  parameter int SW        = $clog2(MAX_PAGES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [SW-1:0] wr_addr,
  input  logic [SW-1:0] wr_next,
  input  logic          wr_valid,
  input  logic          re,
  input  logic [SW-1:0] rd_addr,
  output logic [SW-1:0] rd_next,
  output logic          rd_valid
);
  import pcpfl_pkg::*;

  // each entry: more-on-list bit, next slot
  logic [SW:0] mem [MAX_PAGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= {wr_valid, wr_next};
    end
    if (re) begin
      {rd_valid, rd_next} <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/per_cpu_page_free_list_top.sv
// channel   direction  fields                                  handshake
// in_       input      req_type, cpu_id, page_address          in_valid / in_stall
// out_      output     status, granted_address                 out_valid / out_stall
// cfg_      input      region_start (0x0), region_stop (0x4)   apb, pready always high
//
// free and allocate both read the head memory, and allocate follows it with
// the dependent link memory read.
// a bad free or out of memory finishes in the check stage.
// reset (rst_n low, synchronous) empties all lists; links need no clearing.
// a stalled output holds the finishing stage; the next item is taken as the
// current one hands its result to the output register.
`include "per_cpu_page_free_list_top_macros.svh"

module per_cpu_page_free_list_top #(
  parameter int NUM_REQUESTERS = pcpfl_pkg::DEF_NUM_REQUESTERS,
  parameter int PAGE_BYTES     = pcpfl_pkg::DEF_PAGE_BYTES,
  parameter int MAX_PAGES      = pcpfl_pkg::DEF_MAX_PAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [2:0]  in_cpu_id,
  input  logic [31:0] in_page_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_granted_address,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pcpfl_pkg::*;

  localparam int          SW    = $clog2(MAX_PAGES);
  localparam int          IW    = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
  localparam int          Sh    = $clog2(PAGE_BYTES);
  localparam logic [32:0] PgLow = 33'(PAGE_BYTES - 1);

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_READ, S_POP} state_t;

  function automatic logic [IW-1:0] id_reduce(input logic [2:0] v);
    logic [6:0] t;
    t = 7'(v);
    for (int i = 0; i < 8; i++) begin
      if (t >= 7'(NUM_REQUESTERS)) begin
        t = t - 7'(NUM_REQUESTERS);
      end
    end
    return IW'(t);
  endfunction

  // configuration
  logic [31:0] region_start_r;
  logic [31:0] region_stop_r;
  logic [32:0] base_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_REGION_STOP) ? region_stop_r : region_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= '0;
      region_stop_r  <= '0;
      base_r         <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == CFG_REGION_START) begin
        region_start_r <= cfg_pwdata;
        // region base: start rounded up to a page boundary
        base_r <= ({1'b0, cfg_pwdata & ADDR_MASK} + PgLow) & ~PgLow;
      end else begin
        region_stop_r <= cfg_pwdata;
      end
    end
  end

  // request and control
  state_t        state_r, state_nxt;
  logic          req_alloc_r;
  logic [IW-1:0] id_r;
  logic [31:0]   addr_r;
  logic [IW-1:0] q_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_grant_r;
  logic          out_free;
  logic          finish;
  logic          accept;
  logic [1:0]    st_nxt;
  logic [31:0]   grant_nxt;

  logic          chk_bad;
  logic [SW-1:0] chk_slot;

  head_ctl_t     hd_ctl;
  logic [IW-1:0] hd_rd_addr;
  logic [IW-1:0] hd_wr_addr;
  logic [SW-1:0] hd_wr_slot;
  logic          any_valid;
  logic [IW-1:0] winner;
  logic [SW-1:0] hd_rd_slot;
  logic          hd_rd_valid;

  logic          lk_we;
  logic          lk_re;
  logic [SW-1:0] lk_rd_next;
  logic          lk_rd_valid;

  pcpfl_addr_check #(
    .PAGE_BYTES(PAGE_BYTES),
    .MAX_PAGES (MAX_PAGES),
    .SW        (SW)
  ) u_check (
    .region_start(region_start_r),
    .region_stop (region_stop_r),
    .base        (base_r),
    .addr        (addr_r),
    .bad         (chk_bad),
    .slot        (chk_slot)
  );

  pcpfl_head_store #(
    .NUM_REQUESTERS(NUM_REQUESTERS),
    .SW            (SW),
    .IW            (IW)
  ) u_heads (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (hd_ctl),
    .rd_addr     (hd_rd_addr),
    .wr_addr     (hd_wr_addr),
    .wr_slot     (hd_wr_slot),
    .search_start(id_r),
    .any_valid   (any_valid),
    .winner      (winner),
    .rd_slot     (hd_rd_slot),
    .rd_valid    (hd_rd_valid)
  );

  pcpfl_link_store #(
    .MAX_PAGES(MAX_PAGES),
    .SW       (SW)
  ) u_links (
    .clk     (clk),
    .we      (lk_we),
    .wr_addr (chk_slot),
    .wr_next (hd_rd_slot),
    .wr_valid(hd_rd_valid),
    .re      (lk_re),
    .rd_addr (hd_rd_slot),
    .rd_next (lk_rd_next),
    .rd_valid(lk_rd_valid)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    finish     = 1'b0;
    st_nxt     = ST_FREED;
    grant_nxt  = '0;
    hd_ctl     = '0;
    hd_rd_addr = id_r;
    hd_wr_addr = id_r;
    hd_wr_slot = chk_slot;
    lk_we      = 1'b0;
    lk_re      = 1'b0;
    case (state_r)
      S_IDLE: begin
      end
      S_CHECK: begin
        if (!req_alloc_r) begin
          if (chk_bad) begin
            if (out_free) begin
              finish = 1'b1;
              st_nxt = ST_BAD;
            end
          end else begin
            hd_ctl.rd_en = 1'b1;
            state_nxt    = S_READ;
          end
        end else if (!any_valid) begin
          if (out_free) begin
            finish = 1'b1;
            st_nxt = ST_OOM;
          end
        end else begin
          hd_ctl.rd_en = 1'b1;
          hd_rd_addr   = winner;
          state_nxt    = S_READ;
        end
      end
      S_READ: begin
        if (!req_alloc_r) begin
          // push: old head goes into the page's link, page becomes head
          if (out_free) begin
            finish          = 1'b1;
            st_nxt          = ST_FREED;
            lk_we           = 1'b1;
            hd_ctl.wr_en    = 1'b1;
            hd_ctl.wr_valid = 1'b1;
          end
        end else begin
          lk_re     = 1'b1;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (out_free) begin
          finish          = 1'b1;
          st_nxt          = ST_ALLOC;
          grant_nxt       = (base_r[31:0] + 32'({hd_rd_slot, {Sh{1'b0}}})) & ADDR_MASK;
          hd_ctl.wr_en    = 1'b1;
          hd_ctl.wr_valid = lk_rd_valid;
          hd_wr_addr      = q_r;
          hd_wr_slot      = lk_rd_next;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (finish || state_r == S_IDLE) begin
      state_nxt = in_valid ? S_CHECK : S_IDLE;
    end
  end

  assign in_stall = !rst_n || !(state_r == S_IDLE || finish);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (finish) begin
      out_status_r <= st_nxt;
      out_grant_r  <= grant_nxt;
    end
    if (accept) begin
      req_alloc_r <= in_req_type;
      id_r        <= id_reduce(in_cpu_id);
      addr_r      <= in_page_address;
    end
    if (state_r == S_CHECK) begin
      q_r <= winner;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_grant_r;

  `PCPFL_ASSERT_NOW(a_pop_after_read, state_r == S_POP,
                    $past(state_r) == S_READ || $past(state_r) == S_POP,
                    "pop stage entered without a head read")
  `PCPFL_ASSERT_NOW(a_link_with_head, lk_we,
                    hd_ctl.wr_en && hd_ctl.wr_valid && !req_alloc_r,
                    "link written without a head push")
  `PCPFL_ASSERT_NOW(a_grant_zero, out_valid_r && out_status_r != ST_ALLOC,
                    out_grant_r == 32'd0,
                    "nonzero address on a result that is not a grant")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pcpfl_pkg::*;

  localparam int N_REQ = DEF_NUM_REQUESTERS;
  localparam int N_PAGES = DEF_MAX_PAGES;
  localparam int PAGE_SHIFT = $clog2(DEF_PAGE_BYTES);
  localparam logic [2:0] REG_START_ADDR = {2'b00, CFG_REGION_START} << 2;
  localparam logic [2:0] REG_STOP_ADDR = {2'b00, CFG_REGION_STOP} << 2;
  localparam logic REQ_FREE = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] granted;
  } page_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_req_type;
  logic [2:0] in_cpu_id;
  logic [31:0] in_page_address;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [31:0] out_granted_address;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  per_cpu_page_free_list_top dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [31:0] cur_region_start;
  logic [31:0] cur_region_stop;
  int unsigned head_slot[N_REQ];
  bit head_live[N_REQ];
  int unsigned link_slot[N_PAGES];
  bit link_live[N_PAGES];

  page_result_t pending_results[$];
  int mismatches = 0;
  int cycle_count = 0;
  int pool_pages = 1;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_left = 0;
  int stall_left = 0;

  function automatic logic [32:0] page_base();
    logic [32:0] aligned;
    aligned = {1'b0, (cur_region_start >> PAGE_SHIFT) << PAGE_SHIFT};
    if (cur_region_start[PAGE_SHIFT-1:0] != '0) begin
      return aligned + (33'd1 << PAGE_SHIFT);
    end
    return aligned;
  endfunction

  function automatic page_result_t apply_page_request(logic rt, logic [2:0] id,
                                                      logic [31:0] addr);
    page_result_t res;
    logic [32:0] base;
    logic [32:0] slot;
    int unsigned q;
    bit found;
    base = page_base();
    res.granted = '0;
    found = 1'b0;
    if (rt == REQ_FREE) begin
      res.status = ST_BAD;
      if (addr[PAGE_SHIFT-1:0] == '0 && addr >= cur_region_start &&
          addr < cur_region_stop && {1'b0, addr} >= base) begin
        slot = ({1'b0, addr} - base) >> PAGE_SHIFT;
        if (slot < N_PAGES) begin
          link_slot[slot] = head_slot[id];
          link_live[slot] = head_live[id];
          head_slot[id] = 32'(slot);
          head_live[id] = 1'b1;
          res.status = ST_FREED;
        end
      end
    end else begin
      res.status = ST_OOM;
      // own list first, then round robin from the next id
      for (int k = 0; k < N_REQ; k++) begin
        q = (int'(id) + k) % N_REQ;
        if (!found && head_live[q]) begin
          found = 1'b1;
          slot = 33'(head_slot[q]);
          head_slot[q] = link_slot[slot];
          head_live[q] = link_live[slot];
          res.status = ST_ALLOC;
          res.granted = 32'(base + (slot << PAGE_SHIFT));
        end
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected %h, got %h", what, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    page_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with none pending", '0, out_granted_address);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          flag_mismatch("status", 32'(want.status), 32'(out_status));
        end
        if (out_granted_address !== want.granted) begin
          flag_mismatch("granted_address", want.granted, out_granted_address);
        end
      end
    end
  end

  // receiver side: long holds and random stall bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(logic rt, logic [2:0] id, logic [31:0] addr);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_cpu_id <= id;
    in_page_address <= addr;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_page_request(rt, id, addr));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == REG_START_ADDR) cur_region_start = data;
    else cur_region_stop = data;
    // read back
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== data) flag_mismatch("register readback", data, cfg_prdata);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_region(logic [31:0] start, logic [31:0] stop);
    wait_drained();
    write_reg(REG_START_ADDR, start);
    write_reg(REG_STOP_ADDR, stop);
  endtask

  // region of at least a given number of usable pages at a random place
  task automatic set_random_region(int pages);
    logic [31:0] start;
    logic [32:0] base;
    start = $urandom_range(0, 32'hEFFF_FFFF);
    if ($urandom_range(0, 1) == 1) start[PAGE_SHIFT-1:0] = '0;
    cur_region_start = start;
    base = page_base();
    set_region(start, base[31:0] + (pages << PAGE_SHIFT) + $urandom_range(0, 4095));
    pool_pages = pages;
  endtask

  task automatic run_random(int count, int alloc_pct, bit idle);
    logic [32:0] base;
    logic [31:0] good;
    logic [31:0] addr;
    int r;
    base = page_base();
    tx_idle_on = idle;
    rx_idle_on = idle;
    for (int i = 0; i < count; i++) begin
      if (idle && i % 100 == 50) begin
        tx_idle_on = $urandom_range(0, 2) != 0;
        rx_idle_on = $urandom_range(0, 2) != 0;
      end
      if (i == count / 2) wait_drained();
      r = $urandom_range(0, 99);
      good = base[31:0] + ($urandom_range(0, pool_pages - 1) << PAGE_SHIFT);
      if (r < 7) begin
        send_request(REQ_FREE, 3'($urandom_range(0, 7)), $urandom);
      end else if (r < 12) begin
        case ($urandom_range(0, 3))
          0: addr = good + $urandom_range(1, DEF_PAGE_BYTES - 1);
          1: addr = cur_region_stop;
          2: addr = base[31:0] - DEF_PAGE_BYTES;
          default: addr = base[31:0] + ((N_PAGES + $urandom_range(0, 15)) << PAGE_SHIFT);
        endcase
        send_request(REQ_FREE, 3'($urandom_range(0, 7)), addr);
      end else if (r < 12 + alloc_pct * 88 / 100) begin
        send_request(REQ_ALLOC, 3'($urandom_range(0, 7)), $urandom);
      end else begin
        send_request(REQ_FREE, 3'($urandom_range(0, 7)), good);
      end
    end
  endtask

  task automatic test_reset_region();
    send_request(REQ_FREE, 3'd0, 32'h0000_0000);
    send_request(REQ_ALLOC, 3'd0, 32'h0000_0000);
  endtask

  task automatic test_bad_frees();
    // unaligned start, so the first usable page is 0x2000
    set_region(32'h0000_1001, 32'h0001_0000);
    send_request(REQ_FREE, 3'd1, 32'h0000_2001);
    send_request(REQ_FREE, 3'd1, 32'h0000_1000);
    send_request(REQ_FREE, 3'd1, 32'h0001_0000);
    send_request(REQ_FREE, 3'd1, 32'hFFFF_F000);
  endtask

  task automatic test_own_list_lifo();
    send_request(REQ_FREE, 3'd7, 32'h0000_2000);
    send_request(REQ_FREE, 3'd7, 32'h0000_F000);
    send_request(REQ_ALLOC, 3'd7, 32'hFFFF_FFFF);
    send_request(REQ_ALLOC, 3'd7, 32'h0000_0000);
  endtask

  task automatic test_round_robin();
    send_request(REQ_FREE, 3'd1, 32'h0000_3000);
    send_request(REQ_FREE, 3'd5, 32'h0000_4000);
    send_request(REQ_ALLOC, 3'd6, 32'h0000_0000);
    send_request(REQ_ALLOC, 3'd6, 32'h0000_0000);
    send_request(REQ_ALLOC, 3'd0, 32'h0000_0000);
  endtask

  task automatic test_double_free();
    send_request(REQ_FREE, 3'd3, 32'h0000_5000);
    send_request(REQ_FREE, 3'd3, 32'h0000_5000);
    send_request(REQ_ALLOC, 3'd3, 32'h0000_0000);
    send_request(REQ_ALLOC, 3'd3, 32'h0000_0000);
  endtask

  task automatic test_slot_range();
    set_region(32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_FREE, 3'd0, N_PAGES << PAGE_SHIFT);
    send_request(REQ_FREE, 3'd0, (N_PAGES - 1) << PAGE_SHIFT);
    send_request(REQ_ALLOC, 3'd0, 32'h0000_0000);
  endtask

  task automatic test_region_move();
    send_request(REQ_FREE, 3'd4, 32'h0000_3000);
    // pages already on a list are handed out relative to the new base
    set_region(32'h0010_0800, 32'h0020_0000);
    send_request(REQ_ALLOC, 3'd4, 32'h0000_0000);
  endtask

  task automatic test_random_regions();
    set_region(32'h0000_0000, 32'hFFFF_FFFF);
    pool_pages = 64;
    run_random(180, 40, 1'b1);
    set_random_region(4);
    run_random(180, 50, 1'b1);
    set_random_region(16);
    run_random(180, 35, 1'b1);
    set_random_region(64);
    run_random(180, 60, 1'b1);
    set_random_region(200);
    run_random(180, 45, 1'b1);
  endtask

  task automatic test_top_of_memory();
    set_region(32'hFFFF_F000, 32'hFFFF_FFFF);
    pool_pages = 1;
    run_random(40, 50, 1'b1);
    // base rounds past the 32-bit space: every free is rejected
    set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(30, 50, 1'b1);
  endtask

  task automatic test_backpressure();
    set_random_region(32);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    @(negedge clk);
    for (int i = 0; i < 40; i++) begin
      send_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                   32'(page_base() + 33'($urandom_range(0, 31) << PAGE_SHIFT)));
    end
    wait_drained();
  endtask

  task automatic test_no_idle();
    set_random_region(24);
    run_random(150, 50, 1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_FREE;
    in_cpu_id = '0;
    in_page_address = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cur_region_start = '0;
    cur_region_stop = '0;
    for (int i = 0; i < N_REQ; i++) begin
      head_slot[i] = 0;
      head_live[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_region();
    test_bad_frees();
    test_own_list_lifo();
    test_round_robin();
    test_double_free();
    test_slot_range();
    test_region_move();
    test_random_regions();
    test_top_of_memory();
    test_backpressure();
    test_no_idle();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pcpfl_pkg.sv
rtl/pcpfl_addr_check.sv
rtl/pcpfl_head_store.sv
rtl/pcpfl_link_store.sv
rtl/per_cpu_page_free_list_top.sv
tb/tb_top.sv
